@@ sv/ffrp_pkg.sv @@
// Package for the FASTA/FASTQ record parser: item types, parser state,
// result kinds and character helpers. No dependencies.
`default_nettype none

package ffrp_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned KindW = 3;

  // record formats held in the configuration register
  localparam logic FMT_FASTA = 1'b0;
  localparam logic FMT_FASTQ = 1'b1;

  // result kinds
  localparam logic [KindW-1:0] KIND_HEADER = 3'd0;
  localparam logic [KindW-1:0] KIND_BASE   = 3'd1;
  localparam logic [KindW-1:0] KIND_END    = 3'd2;
  localparam logic [KindW-1:0] KIND_CANCEL = 3'd3;
  localparam logic [KindW-1:0] KIND_ERROR  = 3'd4;

  // FASTQ line phases
  localparam logic [1:0] PHASE_HEADER = 2'd0;
  localparam logic [1:0] PHASE_SEQ    = 2'd1;
  localparam logic [1:0] PHASE_PLUS   = 2'd2;
  localparam logic [1:0] PHASE_QUAL   = 2'd3;

  localparam logic [ByteW-1:0] CHAR_GT = 8'h3E;  // '>'
  localparam logic [ByteW-1:0] CHAR_AT = 8'h40;  // '@'
  localparam logic [ByteW-1:0] CHAR_LF = 8'h0A;  // '\n'
  localparam logic [ByteW-1:0] CHAR_CR = 8'h0D;  // '\r'

  typedef struct packed {
    logic [ByteW-1:0] text_byte;
    logic             end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic [ByteW-1:0] symbol;
    logic [KindW-1:0] kind;
  } out_item_t;

  typedef struct packed {
    logic [1:0] line_phase;
    logic       in_header;
    logic       at_line_start;
    logic       stripping_leading;
    logic       bases_seen;
    logic       header_pending;
    logic       finished;
  } state_t;

  localparam state_t STATE_RESET = '{
    line_phase:        PHASE_HEADER,
    in_header:         1'b0,
    at_line_start:     1'b1,
    stripping_leading: 1'b0,
    bases_seen:        1'b0,
    header_pending:    1'b0,
    finished:          1'b0
  };

  function automatic logic is_ws(input logic [ByteW-1:0] c);
    return (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  function automatic logic [ByteW-1:0] upcase(input logic [ByteW-1:0] c);
    logic [ByteW-1:0] r;
    r = c;
    if ((c >= 8'h61) && (c <= 8'h7A)) begin
      r = c - 8'd32;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ sv/fasta_fastq_record_parser.sv @@
// An accepted request is held in the input register; its result (if any) is then
// loaded into the result register. One request per cycle unless the output stalls;
// the input register loads whenever it is empty or its request moves on, and the
// result register advances whenever it is empty or being taken.
// Reset (async, active low) clears both valid flags, the parser state and
// sets the format register to FASTA. Configuration writes are always ready.
// Top level of the FASTA/FASTQ record parser; depends on ffrp_pkg, ffrp_step.
`default_nettype none

module fasta_fastq_record_parser (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      in_valid_i,
  output logic                     in_stall_o,
  input  wire ffrp_pkg::in_item_t  in_data_i,
  output logic                     out_valid_o,
  input  wire                      out_stall_i,
  output ffrp_pkg::out_item_t      out_data_o,
  input  wire                      cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire                      cfg_data_i
);

  logic                 s1_valid_q;
  ffrp_pkg::in_item_t   s1_item_q;
  logic                 out_valid_q;
  ffrp_pkg::out_item_t  out_item_q;
  ffrp_pkg::state_t     state_q;
  ffrp_pkg::state_t     state_d;
  logic                 file_format_q;
  logic                 advance;
  logic                 step_emit;
  ffrp_pkg::out_item_t  step_result;

  assign advance     = !out_valid_q || !out_stall_i;
  assign in_stall_o  = s1_valid_q && !advance;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_item_q;

  ffrp_step u_step (
    .state_i       (state_q),
    .file_format_i (file_format_q),
    .item_i        (s1_item_q),
    .state_o       (state_d),
    .emit_o        (step_emit),
    .result_o      (step_result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      state_q       <= ffrp_pkg::STATE_RESET;
      file_format_q <= ffrp_pkg::FMT_FASTA;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        file_format_q <= cfg_data_i;
      end
      // load the input register when it is empty or its request moves on
      if (!in_stall_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= s1_valid_q && step_emit;
        if (s1_valid_q) begin
          state_q <= state_d;
        end
      end
    end
  end

  // payload registers: no reset
  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      s1_item_q <= in_data_i;
    end
    if (advance && s1_valid_q && step_emit) begin
      out_item_q <= step_result;
    end
  end

endmodule

`default_nettype wire

@@ sv/ffrp_step.sv @@
// Per-byte parser step: next state and optional result for one input item.
// Depends on ffrp_pkg.
`default_nettype none

module ffrp_step (
  input  wire ffrp_pkg::state_t    state_i,
  input  wire                      file_format_i,
  input  wire ffrp_pkg::in_item_t  item_i,
  output ffrp_pkg::state_t         state_o,
  output logic                     emit_o,
  output ffrp_pkg::out_item_t      result_o
);

  logic [ffrp_pkg::ByteW-1:0] c;
  ffrp_pkg::state_t           s;
  logic                       strip_now;

  assign c = item_i.text_byte;

  always_comb begin
    s         = state_i;
    emit_o    = 1'b0;
    result_o  = '0;
    strip_now = 1'b0;
    if (!state_i.finished) begin
      if (item_i.end_of_stream) begin
        s.finished = 1'b1;
        if (file_format_i == ffrp_pkg::FMT_FASTA) begin
          if (state_i.bases_seen) begin
            emit_o        = 1'b1;
            result_o.kind = ffrp_pkg::KIND_END;
          end else if (state_i.header_pending) begin
            emit_o        = 1'b1;
            result_o.kind = ffrp_pkg::KIND_CANCEL;
          end
          s.bases_seen     = 1'b0;
          s.header_pending = 1'b0;
        end else if ((state_i.line_phase != ffrp_pkg::PHASE_HEADER) ||
                     !state_i.at_line_start) begin
          emit_o        = 1'b1;
          result_o.kind = ffrp_pkg::KIND_ERROR;
        end
      end else if (file_format_i == ffrp_pkg::FMT_FASTA) begin
        if (state_i.in_header) begin
          if (c == ffrp_pkg::CHAR_LF) begin
            s.in_header     = 1'b0;
            s.at_line_start = 1'b1;
          end else begin
            s.at_line_start = 1'b0;
            if (state_i.stripping_leading &&
                (ffrp_pkg::is_ws(c) || (c == ffrp_pkg::CHAR_GT))) begin
              // drop leading whitespace and markers
            end else begin
              s.stripping_leading = 1'b0;
              if (c != ffrp_pkg::CHAR_CR) begin
                emit_o          = 1'b1;
                result_o.symbol = c;
                result_o.kind   = ffrp_pkg::KIND_HEADER;
              end
            end
          end
        end else if (state_i.at_line_start && (c == ffrp_pkg::CHAR_GT)) begin
          if (state_i.bases_seen) begin
            emit_o        = 1'b1;
            result_o.kind = ffrp_pkg::KIND_END;
          end else if (state_i.header_pending) begin
            emit_o        = 1'b1;
            result_o.kind = ffrp_pkg::KIND_CANCEL;
          end
          s.in_header         = 1'b1;
          s.stripping_leading = 1'b1;
          s.at_line_start     = 1'b0;
          s.bases_seen        = 1'b0;
          s.header_pending    = 1'b1;
        end else if (c == ffrp_pkg::CHAR_LF) begin
          s.at_line_start = 1'b1;
        end else begin
          s.at_line_start = 1'b0;
          if (!ffrp_pkg::is_ws(c)) begin
            s.bases_seen    = 1'b1;
            emit_o          = 1'b1;
            result_o.symbol = ffrp_pkg::upcase(c);
            result_o.kind   = ffrp_pkg::KIND_BASE;
          end
        end
      end else begin
        case (state_i.line_phase)
          ffrp_pkg::PHASE_HEADER: begin
            if (c == ffrp_pkg::CHAR_LF) begin
              s.line_phase    = ffrp_pkg::PHASE_SEQ;
              s.at_line_start = 1'b1;
            end else begin
              strip_now = state_i.stripping_leading || state_i.at_line_start;
              s.at_line_start     = 1'b0;
              s.stripping_leading = strip_now;
              if (strip_now && (ffrp_pkg::is_ws(c) || (c == ffrp_pkg::CHAR_AT))) begin
                // drop leading whitespace and '@'
              end else begin
                s.stripping_leading = 1'b0;
                if (c != ffrp_pkg::CHAR_CR) begin
                  emit_o          = 1'b1;
                  result_o.symbol = c;
                  result_o.kind   = ffrp_pkg::KIND_HEADER;
                end
              end
            end
          end
          ffrp_pkg::PHASE_SEQ: begin
            if (c == ffrp_pkg::CHAR_LF) begin
              s.line_phase    = ffrp_pkg::PHASE_PLUS;
              s.at_line_start = 1'b1;
            end else begin
              s.at_line_start = 1'b0;
              if (!ffrp_pkg::is_ws(c)) begin
                s.bases_seen    = 1'b1;
                emit_o          = 1'b1;
                result_o.symbol = ffrp_pkg::upcase(c);
                result_o.kind   = ffrp_pkg::KIND_BASE;
              end
            end
          end
          ffrp_pkg::PHASE_PLUS: begin
            if (c == ffrp_pkg::CHAR_LF) begin
              s.line_phase    = ffrp_pkg::PHASE_QUAL;
              s.at_line_start = 1'b1;
            end else begin
              s.at_line_start = 1'b0;
            end
          end
          default: begin
            if (c != ffrp_pkg::CHAR_LF) begin
              s.at_line_start = 1'b0;
            end else begin
              s.at_line_start = 1'b1;
              s.line_phase    = ffrp_pkg::PHASE_HEADER;
              emit_o          = 1'b1;
              if (state_i.bases_seen) begin
                s.bases_seen  = 1'b0;
                result_o.kind = ffrp_pkg::KIND_END;
              end else begin
                // empty sequence: withdraw the header and stop
                s.finished    = 1'b1;
                result_o.kind = ffrp_pkg::KIND_CANCEL;
              end
            end
          end
        endcase
      end
    end
    state_o = s;
  end

endmodule

`default_nettype wire

@@ sv/ffrp_checker.sv @@
// Port-level checks for the FASTA/FASTQ record parser, bound to the top level.
// Depends on ffrp_pkg and fasta_fastq_record_parser.
`default_nettype none

module ffrp_checker (
  input wire                      clk_i,
  input wire                      rst_ni,
  input wire                      out_valid_o,
  input wire                      out_stall_i,
  input wire ffrp_pkg::out_item_t out_data_o
);

  // no result during reset
  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("result valid during reset");

  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.kind <= ffrp_pkg::KIND_ERROR))
    else $error("result kind out of range");

  // marker kinds carry a zero symbol
  a_marker_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.kind >= ffrp_pkg::KIND_END)) |-> (out_data_o.symbol == '0))
    else $error("marker result with nonzero symbol");

  // bases are upper case and never whitespace
  a_base_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.kind == ffrp_pkg::KIND_BASE)) |->
      (!ffrp_pkg::is_ws(out_data_o.symbol) &&
       !((out_data_o.symbol >= 8'h61) && (out_data_o.symbol <= 8'h7A))))
    else $error("base symbol is whitespace or lower case");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled result dropped or changed");

endmodule

bind fasta_fastq_record_parser ffrp_checker u_ffrp_checker (.*);

`default_nettype wire

@@ tb/fasta_fastq_record_parser_tb.sv @@
// Self-checking testbench for fasta_fastq_record_parser: directed and random
// FASTA/FASTQ text checked against an in-bench parser model.
// Depends on ffrp_pkg and the fasta_fastq_record_parser RTL.
`timescale 1ns / 1ps

module fasta_fastq_record_parser_tb;

  localparam int CLK_PERIOD     = 12;
  localparam int TIMEOUT_CYCLES = 600000;
  localparam int ITEM_GOAL      = 1100;
  localparam int SETTLE_CYCLES  = 4;
  localparam int LONG_HOLD      = 200;

  logic                clk_i;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  ffrp_pkg::in_item_t  in_data_i   = '0;
  logic                in_stall_o;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  ffrp_pkg::out_item_t out_data_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic                cfg_data_i  = 1'b0;

  fasta_fastq_record_parser uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  ffrp_pkg::in_item_t  text_q[$];
  ffrp_pkg::out_item_t results_due_q[$];
  ffrp_pkg::out_item_t due;
  int        queued_total = 0;
  int        items_taken;
  int        mismatches   = 0;
  int        gap_cnt;
  int        burst_cnt;
  int        stall_cnt;
  logic      long_hold_done;

  // parser model state
  logic       fmt_reg;
  logic [1:0] fq_phase;
  logic       hdr_line;
  logic       line_start;
  logic       strip_lead;
  logic       got_bases;
  logic       hdr_waiting;
  logic       parse_done;

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  initial begin
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("fasta_fastq_record_parser regression: fail");
    $finish;
  end

  // ---------------------------------------------------------------- model

  function automatic logic blank_char(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic [7:0] upper_char(input logic [7:0] c);
    return (c >= "a" && c <= "z") ? c - 8'd32 : c;
  endfunction

  function automatic void add_result(input logic [7:0] sym,
                                     input logic [ffrp_pkg::KindW-1:0] kind);
    results_due_q.insert(results_due_q.size(),
                         ffrp_pkg::out_item_t'{symbol: sym, kind: kind});
  endfunction

  function automatic void fasta_char(input logic [7:0] c);
    if (hdr_line) begin
      if (c == ffrp_pkg::CHAR_LF) begin
        hdr_line   = 1'b0;
        line_start = 1'b1;
      end else begin
        line_start = 1'b0;
        // drop leading blanks and markers of the header
        if (!(strip_lead && (blank_char(c) || c == ffrp_pkg::CHAR_GT))) begin
          strip_lead = 1'b0;
          if (c != ffrp_pkg::CHAR_CR) add_result(c, ffrp_pkg::KIND_HEADER);
        end
      end
    end else if (line_start && c == ffrp_pkg::CHAR_GT) begin
      if (got_bases) add_result(8'h00, ffrp_pkg::KIND_END);
      else if (hdr_waiting) add_result(8'h00, ffrp_pkg::KIND_CANCEL);
      hdr_line    = 1'b1;
      strip_lead  = 1'b1;
      line_start  = 1'b0;
      got_bases   = 1'b0;
      hdr_waiting = 1'b1;
    end else if (c == ffrp_pkg::CHAR_LF) begin
      line_start = 1'b1;
    end else begin
      line_start = 1'b0;
      if (!blank_char(c)) begin
        got_bases = 1'b1;
        add_result(upper_char(c), ffrp_pkg::KIND_BASE);
      end
    end
  endfunction

  function automatic void fastq_char(input logic [7:0] c);
    case (fq_phase)
      ffrp_pkg::PHASE_HEADER: begin
        if (c == ffrp_pkg::CHAR_LF) begin
          fq_phase   = ffrp_pkg::PHASE_SEQ;
          line_start = 1'b1;
        end else begin
          if (line_start) begin
            strip_lead = 1'b1;
            line_start = 1'b0;
          end
          if (!(strip_lead && (blank_char(c) || c == ffrp_pkg::CHAR_AT))) begin
            strip_lead = 1'b0;
            if (c != ffrp_pkg::CHAR_CR) add_result(c, ffrp_pkg::KIND_HEADER);
          end
        end
      end
      ffrp_pkg::PHASE_SEQ: begin
        if (c == ffrp_pkg::CHAR_LF) begin
          fq_phase   = ffrp_pkg::PHASE_PLUS;
          line_start = 1'b1;
        end else begin
          line_start = 1'b0;
          if (!blank_char(c)) begin
            got_bases = 1'b1;
            add_result(upper_char(c), ffrp_pkg::KIND_BASE);
          end
        end
      end
      ffrp_pkg::PHASE_PLUS: begin
        if (c == ffrp_pkg::CHAR_LF) begin
          fq_phase   = ffrp_pkg::PHASE_QUAL;
          line_start = 1'b1;
        end else begin
          line_start = 1'b0;
        end
      end
      default: begin
        if (c != ffrp_pkg::CHAR_LF) begin
          line_start = 1'b0;
        end else begin
          line_start = 1'b1;
          fq_phase   = ffrp_pkg::PHASE_HEADER;
          if (got_bases) begin
            got_bases = 1'b0;
            add_result(8'h00, ffrp_pkg::KIND_END);
          end else begin
            // empty sequence withdraws the header and stops parsing
            parse_done = 1'b1;
            add_result(8'h00, ffrp_pkg::KIND_CANCEL);
          end
        end
      end
    endcase
  endfunction

  function automatic void parse_item(input ffrp_pkg::in_item_t it);
    if (parse_done) return;
    if (it.end_of_stream) begin
      parse_done = 1'b1;
      if (fmt_reg == ffrp_pkg::FMT_FASTA) begin
        if (got_bases) add_result(8'h00, ffrp_pkg::KIND_END);
        else if (hdr_waiting) add_result(8'h00, ffrp_pkg::KIND_CANCEL);
        got_bases   = 1'b0;
        hdr_waiting = 1'b0;
      end else if (fq_phase != ffrp_pkg::PHASE_HEADER || !line_start) begin
        add_result(8'h00, ffrp_pkg::KIND_ERROR);
      end
    end else if (fmt_reg == ffrp_pkg::FMT_FASTA) begin
      fasta_char(it.text_byte);
    end else begin
      fastq_char(it.text_byte);
    end
  endfunction

  // ------------------------------------------------------------ stimulus

  function automatic int run_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void queue_item(input logic [7:0] c, input logic eos);
    text_q.insert(text_q.size(),
                  ffrp_pkg::in_item_t'{text_byte: c, end_of_stream: eos});
    queued_total++;
  endfunction

  function automatic void queue_byte(input logic [7:0] c);
    queue_item(c, 1'b0);
  endfunction

  function automatic void queue_text(input string s);
    for (int i = 0; i < s.len(); i++) queue_byte(s[i]);
  endfunction

  function automatic logic [7:0] any_byte(input bit allow_lf);
    int r;
    r = $urandom_range(0, allow_lf ? 255 : 254);
    if (!allow_lf && r >= ffrp_pkg::CHAR_LF) r++;
    return 8'(r);
  endfunction

  function automatic logic [7:0] base_letter();
    logic [7:0] c;
    case ($urandom_range(0, 4))
      0:       c = "A";
      1:       c = "C";
      2:       c = "G";
      3:       c = "T";
      default: c = "N";
    endcase
    if ($urandom_range(0, 2) == 0) c = c + 8'd32;
    return c;
  endfunction

  function automatic logic [7:0] seq_char(input bit allow_lf);
    logic [7:0] c;
    int r;
    r = $urandom_range(0, 19);
    if (r < 14) return base_letter();
    if (r == 14) return 8'h20;
    if (r == 15) begin
      c = 8'($urandom_range(9, 13));
      if (!allow_lf && c == ffrp_pkg::CHAR_LF) c = 8'h20;
      return c;
    end
    return any_byte(allow_lf);
  endfunction

  function automatic logic [7:0] header_char();
    case ($urandom_range(0, 9))
      0:       return ffrp_pkg::CHAR_CR;
      1:       return 8'h20;
      2:       return any_byte(1'b0);
      default: return 8'($urandom_range(33, 126));
    endcase
  endfunction

  function automatic void gen_fasta_record();
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 10)) queue_byte(any_byte(1'b1));
      return;
    end
    queue_byte(ffrp_pkg::CHAR_GT);
    repeat ($urandom_range(0, 2))
      queue_byte($urandom_range(0, 1) ? ffrp_pkg::CHAR_GT : 8'h20);
    repeat ($urandom_range(0, 8)) queue_byte(header_char());
    queue_byte(ffrp_pkg::CHAR_LF);
    // zero lines leaves a header with no bases
    repeat ($urandom_range(0, 3)) begin
      repeat ($urandom_range(0, 12)) queue_byte(seq_char(1'b1));
      queue_byte(ffrp_pkg::CHAR_LF);
    end
  endfunction

  // complete record, never an empty sequence: parsing must not stop early
  function automatic void gen_fastq_record();
    if ($urandom_range(0, 4) != 0) queue_byte(ffrp_pkg::CHAR_AT);
    repeat ($urandom_range(0, 2))
      queue_byte($urandom_range(0, 1) ? ffrp_pkg::CHAR_AT : 8'h09);
    repeat ($urandom_range(0, 8)) queue_byte(header_char());
    queue_byte(ffrp_pkg::CHAR_LF);
    repeat ($urandom_range(0, 10)) queue_byte(seq_char(1'b0));
    queue_byte(base_letter());
    if ($urandom_range(0, 3) == 0) queue_byte(ffrp_pkg::CHAR_CR);
    queue_byte(ffrp_pkg::CHAR_LF);
    queue_byte("+");
    repeat ($urandom_range(0, 3)) queue_byte(header_char());
    queue_byte(ffrp_pkg::CHAR_LF);
    repeat ($urandom_range(0, 12)) queue_byte(header_char());
    queue_byte(ffrp_pkg::CHAR_LF);
  endfunction

  task automatic wait_idle();
    do @(negedge clk_i);
    while (text_q.size() != 0 || in_valid_i || results_due_q.size() != 0);
    // requests that produce nothing may still be in the pipeline
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_format(input logic fmt);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= fmt;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    fmt_reg = fmt;
  endtask

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("%0t ns: %s got %h expected %h", $time, what, got, want);
    mismatches++;
  endtask

  initial begin
    int goal;
    int ending;
    logic fmt;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait_idle();
    write_format(ffrp_pkg::FMT_FASTA);
    queue_text("ac\n");            // bases ahead of any header
    queue_text(">\t>Hi\r\n");      // strip blanks and markers, drop CR
    queue_text("g>t \n");          // '>' inside a line is a base
    queue_byte(8'h00);
    queue_byte(8'hFF);
    queue_byte(ffrp_pkg::CHAR_LF);
    queue_text(">e\n>f\nz\n");     // header e gets no bases: cancel

    wait_idle();
    write_format(ffrp_pkg::FMT_FASTQ);
    queue_text(" @ @r\r\nacgT\n+x\n!!~!\n");
    queue_text("q\nN\n+\n\n");     // header without '@'

    while (queued_total < ITEM_GOAL) begin
      wait_idle();
      fmt = 1'($urandom_range(0, 1));
      write_format(fmt);
      goal = queued_total + $urandom_range(60, 160);
      while (queued_total < goal) begin
        if (fmt == ffrp_pkg::FMT_FASTQ) gen_fastq_record();
        else gen_fasta_record();
      end
    end

    // only one way to end the stream per run, since reset comes once
    wait_idle();
    ending = $urandom_range(0, 4);
    write_format((ending < 2) ? ffrp_pkg::FMT_FASTA : ffrp_pkg::FMT_FASTQ);
    case (ending)
      0: queue_text("\n>tail\nACGT");
      1: queue_text("\n>lonely\n");
      2: begin
        gen_fastq_record();
        queue_text("@trunc\nAC");
      end
      3: begin
        gen_fastq_record();
        queue_text("@empty\n \t\n+\n\n");
      end
      default: gen_fastq_record();
    endcase
    if (ending != 3) queue_item(8'h00, 1'b1);
    // everything after the stream stops must be ignored
    repeat (16) queue_item(any_byte(1'b1), 1'($urandom_range(0, 1)));

    wait_idle();
    if (mismatches == 0) begin
      $display("fasta_fastq_record_parser regression: pass");
    end else begin
      $display("fasta_fastq_record_parser regression: fail");
    end
    $finish;
  end

  // -------------------------------------------------------------- driver

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      in_data_i   <= '0;
      gap_cnt     <= 0;
      burst_cnt   <= 0;
      items_taken <= 0;
      fmt_reg     = ffrp_pkg::FMT_FASTA;
      fq_phase    = ffrp_pkg::PHASE_HEADER;
      hdr_line    = 1'b0;
      line_start  = 1'b1;
      strip_lead  = 1'b0;
      got_bases   = 1'b0;
      hdr_waiting = 1'b0;
      parse_done  = 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        parse_item(in_data_i);
        items_taken <= items_taken + 1;
      end
      // hold the request while stalled
      if (!in_valid_i || !in_stall_o) begin
        if (gap_cnt != 0) begin
          in_valid_i <= 1'b0;
          gap_cnt    <= gap_cnt - 1;
        end else if (text_q.size() != 0) begin
          in_valid_i <= 1'b1;
          in_data_i  <= text_q[0];
          text_q.delete(0);
          if (burst_cnt != 0) begin
            burst_cnt <= burst_cnt - 1;
          end else begin
            gap_cnt   <= run_len();
            burst_cnt <= run_len();
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ------------------------------------------------------------- monitor

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i    <= 1'b0;
      stall_cnt      <= 0;
      long_hold_done <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (results_due_q.size() == 0) begin
          report_mismatch("unexpected result, kind", 8'(out_data_o.kind), 8'h00);
        end else begin
          due = results_due_q[0];
          results_due_q.delete(0);
          if (out_data_o.symbol !== due.symbol)
            report_mismatch("symbol", out_data_o.symbol, due.symbol);
          if (out_data_o.kind !== due.kind)
            report_mismatch("kind", 8'(out_data_o.kind), 8'(due.kind));
        end
      end
      // one long hold while the sender keeps pushing, to back up the pipeline
      if (!long_hold_done && items_taken > 200 && text_q.size() > 30) begin
        out_stall_i    <= 1'b1;
        stall_cnt      <= LONG_HOLD;
        long_hold_done <= 1'b1;
      end else if (stall_cnt != 0) begin
        stall_cnt <= stall_cnt - 1;
      end else begin
        out_stall_i <= ($urandom_range(0, 2) == 0);
        stall_cnt   <= run_len();
      end
    end
  end

endmodule
